// ===== design/cpd_pkg.sv =====
// cpd_pkg: shared constants, configuration indexes and the queue entry type
// of the command packet deserializer
// no dependencies
package cpd_pkg;

  localparam int unsigned PosW      = 11;
  localparam int unsigned LenW      = PosW + 1;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  localparam int unsigned HeaderBytes = 26;
  localparam int unsigned MaxIds      = 256;

  localparam logic [PosW-1:0] PosMax      = '1;
  localparam logic [PosW-1:0] PosMagic0   = PosW'(0);
  localparam logic [PosW-1:0] PosMagic1   = PosW'(1);
  localparam logic [PosW-1:0] PosMagic2   = PosW'(2);
  localparam logic [PosW-1:0] PosVersion  = PosW'(3);
  localparam logic [PosW-1:0] PosTickEnd  = PosW'(7);
  localparam logic [PosW-1:0] PosSeqEnd   = PosW'(11);
  localparam logic [PosW-1:0] PosPlayer   = PosW'(12);
  localparam logic [PosW-1:0] PosOrder    = PosW'(13);
  localparam logic [PosW-1:0] PosXEnd     = PosW'(17);
  localparam logic [PosW-1:0] PosZEnd     = PosW'(21);
  localparam logic [PosW-1:0] PosCountEnd = PosW'(25);
  localparam logic [PosW-1:0] PosIdStart  = PosW'(HeaderBytes);
  localparam logic [1:0]      IdPhase     = 2'((HeaderBytes + 3) % 4);

  localparam logic [7:0] MagicV   = 8'h56;
  localparam logic [7:0] MagicF   = 8'h46;
  localparam logic [7:0] MagicC   = 8'h43;
  localparam logic [7:0] Version  = 8'h01;
  localparam logic [7:0] PlayerLimit = 8'd2;
  localparam logic [7:0] OrderMax    = 8'd3;

  localparam logic [CfgIdxW-1:0] CfgXLimit = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgZLimit = CfgIdxW'(1);
  localparam logic [31:0]        LimitReset = 32'd32768;

  localparam logic KindId      = 1'b0;
  localparam logic KindVerdict = 1'b1;

  typedef struct packed {
    logic        has_id;
    logic [31:0] id;
    logic        has_verdict;
    logic        accepted;
    logic [31:0] tick;
    logic [31:0] seq;
    logic [7:0]  player;
    logic [7:0]  order;
    logic [31:0] x;
    logic [31:0] z;
    logic [31:0] count;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== design/cpd_channels.sv =====
// cpd_channels: valid/ready channel interfaces for packet bytes, results and
// configuration writes
// depends on cpd_pkg
interface cpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;
  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface cpd_result_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [31:0] unit_id;
  logic        accepted;
  logic [31:0] tick_value;
  logic [31:0] sequence_value;
  logic [7:0]  player_value;
  logic [7:0]  order_value;
  logic [31:0] x_value;
  logic [31:0] z_value;
  logic [31:0] id_count;
  modport source (output valid, output item_kind, output unit_id, output accepted,
                  output tick_value, output sequence_value, output player_value,
                  output order_value, output x_value, output z_value, output id_count,
                  input ready);
  modport sink   (input valid, input item_kind, input unit_id, input accepted,
                  input tick_value, input sequence_value, input player_value,
                  input order_value, input x_value, input z_value, input id_count,
                  output ready);
endinterface

interface cpd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cpd_pkg::CfgIdxW-1:0] index;
  logic [31:0]                 data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/cpd_front.sv =====
// cpd_front: byte acceptance, header assembly, checks and verdict, pushing
// id and verdict entries into the queue
// depends on cpd_pkg and cpd_channels
module cpd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  cpd_byte_if.sink          byte_i,
  cpd_cfg_if.sink           cfg_i,
  input  cpd_pkg::q_stat_t  q_stat_i,
  output logic              push_o,
  output cpd_pkg::entry_t   entry_o
);

  logic [cpd_pkg::PosW-1:0] pos_q, pos_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] tick_q, tick_d;
  logic [31:0] seq_q, seq_d;
  logic [7:0]  player_q, player_d;
  logic [7:0]  order_q, order_d;
  logic [31:0] x_q, x_d;
  logic [31:0] z_q, z_d;
  logic [31:0] count_q, count_d;
  logic [31:0] prev_q, prev_d;
  logic        err_q, err_d;
  logic [31:0] x_limit_q, z_limit_q;

  logic [7:0] b;
  logic       accept, sat, id_done, magic_bad, id_bad, ok;
  logic [cpd_pkg::LenW-1:0] len, exp_len;

  assign cfg_i.ready  = 1'b1;
  assign byte_i.ready = !q_stat_i.full;

  always_comb begin
    b       = byte_i.data_byte;
    accept  = byte_i.valid && !q_stat_i.full;
    sat     = (pos_q == cpd_pkg::PosMax);
    shift_d = sat ? shift_q : {b, shift_q[31:8]};

    tick_d   = (!sat && pos_q == cpd_pkg::PosTickEnd)  ? shift_d : tick_q;
    seq_d    = (!sat && pos_q == cpd_pkg::PosSeqEnd)   ? shift_d : seq_q;
    player_d = (!sat && pos_q == cpd_pkg::PosPlayer)   ? b       : player_q;
    order_d  = (!sat && pos_q == cpd_pkg::PosOrder)    ? b       : order_q;
    x_d      = (!sat && pos_q == cpd_pkg::PosXEnd)     ? shift_d : x_q;
    z_d      = (!sat && pos_q == cpd_pkg::PosZEnd)     ? shift_d : z_q;
    count_d  = (!sat && pos_q == cpd_pkg::PosCountEnd) ? shift_d : count_q;

    // an id completes on every fourth byte past the header
    id_done = !sat && (pos_q >= cpd_pkg::PosIdStart) && (pos_q[1:0] == cpd_pkg::IdPhase);

    magic_bad = !sat && ((pos_q == cpd_pkg::PosMagic0  && b != cpd_pkg::MagicV) ||
                         (pos_q == cpd_pkg::PosMagic1  && b != cpd_pkg::MagicF) ||
                         (pos_q == cpd_pkg::PosMagic2  && b != cpd_pkg::MagicC) ||
                         (pos_q == cpd_pkg::PosVersion && b != cpd_pkg::Version));
    id_bad = id_done && (shift_d <= prev_q);
    err_d  = err_q || sat || magic_bad || id_bad;
    prev_d = id_done ? shift_d : prev_q;
    pos_d  = sat ? pos_q : pos_q + 1'b1;

    // length of the packet including this byte
    len     = {1'b0, pos_q} + 1'b1;
    exp_len = cpd_pkg::LenW'(cpd_pkg::HeaderBytes) + {1'b0, count_d[8:0], 2'b00};

    ok = !err_d &&
         (len >= cpd_pkg::LenW'(cpd_pkg::HeaderBytes)) &&
         (count_d != 32'd0) && (count_d <= 32'(cpd_pkg::MaxIds)) &&
         (len == exp_len) &&
         (player_d < cpd_pkg::PlayerLimit) &&
         (seq_d != 32'd0) &&
         (order_d <= cpd_pkg::OrderMax) &&
         (x_d < x_limit_q) &&
         (z_d < z_limit_q);

    entry_o.has_id      = id_done;
    entry_o.id          = shift_d;
    entry_o.has_verdict = byte_i.end_of_packet;
    entry_o.accepted    = ok;
    entry_o.tick        = tick_d;
    entry_o.seq         = seq_d;
    entry_o.player      = player_d;
    entry_o.order       = order_d;
    entry_o.x           = x_d;
    entry_o.z           = z_d;
    entry_o.count       = count_d;

    push_o = accept && (id_done || byte_i.end_of_packet);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q <= cpd_pkg::LimitReset;
      z_limit_q <= cpd_pkg::LimitReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == cpd_pkg::CfgXLimit) begin
        x_limit_q <= cfg_i.data;
      end
      if (cfg_i.index == cpd_pkg::CfgZLimit) begin
        z_limit_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      shift_q  <= '0;
      tick_q   <= '0;
      seq_q    <= '0;
      player_q <= '0;
      order_q  <= '0;
      x_q      <= '0;
      z_q      <= '0;
      count_q  <= '0;
      prev_q   <= '0;
      err_q    <= 1'b0;
    end else if (accept) begin
      if (byte_i.end_of_packet) begin
        pos_q    <= '0;
        shift_q  <= '0;
        tick_q   <= '0;
        seq_q    <= '0;
        player_q <= '0;
        order_q  <= '0;
        x_q      <= '0;
        z_q      <= '0;
        count_q  <= '0;
        prev_q   <= '0;
        err_q    <= 1'b0;
      end else begin
        pos_q    <= pos_d;
        shift_q  <= shift_d;
        tick_q   <= tick_d;
        seq_q    <= seq_d;
        player_q <= player_d;
        order_q  <= order_d;
        x_q      <= x_d;
        z_q      <= z_d;
        count_q  <= count_d;
        prev_q   <= prev_d;
        err_q    <= err_d;
      end
    end
  end

endmodule

// ===== design/cpd_queue.sv =====
// cpd_queue: short first-in first-out queue of entries between front and back
// depends on cpd_pkg
module cpd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cpd_pkg::entry_t   entry_i,
  input  logic              pop_i,
  output cpd_pkg::entry_t   head_o,
  output cpd_pkg::q_stat_t  stat_o
);

  cpd_pkg::entry_t mem_q [cpd_pkg::QDepth];
  logic [cpd_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [cpd_pkg::QCntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign stat_o.full  = (cnt_q == cpd_pkg::QCntW'(cpd_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == cpd_pkg::QPtrW'(cpd_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == cpd_pkg::QPtrW'(cpd_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // the front must never push into a full queue, nor the back pop an empty one
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cpd_pkg::QCntW'(cpd_pkg::QDepth)) else $error("queue count overrun");

endmodule

// ===== design/cpd_back.sv =====
// cpd_back: drains queue entries into result transactions through an output
// register, splitting an entry with an id and a verdict into two items
// depends on cpd_pkg and cpd_channels
module cpd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpd_pkg::entry_t   head_i,
  input  cpd_pkg::q_stat_t  q_stat_i,
  output logic              pop_o,
  cpd_result_if.source      result_o
);

  logic        valid_q;
  logic        id_sent_q;
  logic        kind_q;
  logic [31:0] id_q;
  logic        acc_q;
  logic [31:0] tick_q, seq_q, x_q, z_q, count_q;
  logic [7:0]  player_q, order_q;
  logic        load, emit_id;

  assign load    = !valid_q || result_o.ready;
  assign emit_id = head_i.has_id && !id_sent_q;
  assign pop_o   = load && !q_stat_i.empty && !(emit_id && head_i.has_verdict);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      id_sent_q <= 1'b0;
    end else if (load) begin
      valid_q <= !q_stat_i.empty;
      if (!q_stat_i.empty) begin
        id_sent_q <= emit_id && head_i.has_verdict;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !q_stat_i.empty) begin
      if (emit_id) begin
        kind_q   <= cpd_pkg::KindId;
        id_q     <= head_i.id;
        acc_q    <= 1'b0;
        tick_q   <= '0;
        seq_q    <= '0;
        player_q <= '0;
        order_q  <= '0;
        x_q      <= '0;
        z_q      <= '0;
        count_q  <= '0;
      end else begin
        kind_q   <= cpd_pkg::KindVerdict;
        id_q     <= '0;
        acc_q    <= head_i.accepted;
        tick_q   <= head_i.tick;
        seq_q    <= head_i.seq;
        player_q <= head_i.player;
        order_q  <= head_i.order;
        x_q      <= head_i.x;
        z_q      <= head_i.z;
        count_q  <= head_i.count;
      end
    end
  end

  assign result_o.valid          = valid_q;
  assign result_o.item_kind      = kind_q;
  assign result_o.unit_id        = id_q;
  assign result_o.accepted       = acc_q;
  assign result_o.tick_value     = tick_q;
  assign result_o.sequence_value = seq_q;
  assign result_o.player_value   = player_q;
  assign result_o.order_value    = order_q;
  assign result_o.x_value        = x_q;
  assign result_o.z_value        = z_q;
  assign result_o.id_count       = count_q;

  // a half-sent entry stays at the head until its verdict goes out
  a_split_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    id_sent_q |-> (!q_stat_i.empty && head_i.has_verdict)) else $error("lost split entry");
  a_split_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    id_sent_q |-> (valid_q && kind_q == cpd_pkg::KindId)) else $error("split out of order");

endmodule

// ===== design/command_packet_deserializer_top.sv =====
// command_packet_deserializer_top: top level of the command packet deserializer
// depends on cpd_pkg, cpd_channels, cpd_front, cpd_queue and cpd_back
//
// Takes a command packet one byte per transaction on byte_i, the final byte
// marked by end_of_packet, and returns result transactions on result_o: an
// id item (item_kind 0) each time a four-byte unit id past the 26-byte header
// completes, and one verdict item (item_kind 1) for the final byte carrying
// the accept flag and the decoded header; when the final byte also completes
// an id, the id item comes first. One byte is accepted per cycle as long as
// the four-entry queue between the front and the back has room; the back
// delivers one result per cycle while result_o is ready, so an entry holding
// both an id and a verdict goes out as two items and the queue absorbs the
// difference. A result passes through the queue and then the output register
// before it is presented on result_o, and a verdict that shares its byte with
// an id item follows that id item.
// Limit registers x_limit (index 0) and z_limit (index 1) are to be written
// through cfg_i only while the block is idle, which the block itself does not enforce; other indexes are ignored.

module command_packet_deserializer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  cpd_byte_if.sink      byte_i,
  cpd_cfg_if.sink       cfg_i,
  cpd_result_if.source  result_o
);

  // queue handshake between the front and the back
  logic             push, pop;
  cpd_pkg::entry_t  push_entry, head_entry;
  cpd_pkg::q_stat_t q_stat;

  // front: byte counting, header assembly, checks and verdict
  cpd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_i),
    .cfg_i    (cfg_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  // decoupling queue
  cpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .stat_o  (q_stat)
  );

  // back: result formatting and output register
  cpd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head_entry),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

// ===== tb/cpd_packet_checker.sv =====
`timescale 1ns / 100ps
// cpd_packet_checker: watches the byte, configuration and result channels of the
// command packet deserializer, predicts every result and compares it field by field
// depends on cpd_pkg and cpd_channels
module cpd_packet_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  cpd_byte_if    byte_i,
  cpd_cfg_if     cfg_i,
  cpd_result_if  result_i,
  output int     pending_o,
  output int     mismatches_o
);

  typedef struct packed {
    logic        kind;
    logic [31:0] unit_id;
    logic        accepted;
    logic [31:0] tick;
    logic [31:0] seq;
    logic [7:0]  player;
    logic [7:0]  order;
    logic [31:0] x;
    logic [31:0] z;
    logic [31:0] count;
  } result_item_t;

  // predicted packet state and limits
  logic [cpd_pkg::PosW-1:0] rx_count;
  logic [31:0]     last_four;
  logic [31:0]     hdr_tick;
  logic [31:0]     hdr_seq;
  logic [7:0]      hdr_player;
  logic [7:0]      hdr_order;
  logic [31:0]     hdr_x;
  logic [31:0]     hdr_z;
  logic [31:0]     hdr_count;
  logic [31:0]     prior_id;
  logic            bad_packet;
  logic [31:0]     lim_x;
  logic [31:0]     lim_z;

  result_item_t expected_items[$];

  task automatic restart_packet();
    rx_count   = '0;
    last_four  = '0;
    hdr_tick   = '0;
    hdr_seq    = '0;
    hdr_player = '0;
    hdr_order  = '0;
    hdr_x      = '0;
    hdr_z      = '0;
    hdr_count  = '0;
    prior_id   = '0;
    bad_packet = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [cpd_pkg::PosW-1:0] pos;
    logic [cpd_pkg::PosW-1:0] id_off;
    logic [cpd_pkg::LenW-1:0] pkt_len;
    logic [35:0]     want_len;
    logic            ok;
    result_item_t    item;
    pos = rx_count;
    if (pos == cpd_pkg::PosMax) begin
      // counter saturated, packet too long
      bad_packet = 1'b1;
    end else begin
      last_four = {b, last_four[31:8]};
      case (pos)
        cpd_pkg::PosMagic0:   if (b != cpd_pkg::MagicV) bad_packet = 1'b1;
        cpd_pkg::PosMagic1:   if (b != cpd_pkg::MagicF) bad_packet = 1'b1;
        cpd_pkg::PosMagic2:   if (b != cpd_pkg::MagicC) bad_packet = 1'b1;
        cpd_pkg::PosVersion:  if (b != cpd_pkg::Version) bad_packet = 1'b1;
        cpd_pkg::PosTickEnd:  hdr_tick = last_four;
        cpd_pkg::PosSeqEnd:   hdr_seq = last_four;
        cpd_pkg::PosPlayer:   hdr_player = b;
        cpd_pkg::PosOrder:    hdr_order = b;
        cpd_pkg::PosXEnd:     hdr_x = last_four;
        cpd_pkg::PosZEnd:     hdr_z = last_four;
        cpd_pkg::PosCountEnd: hdr_count = last_four;
        default: ;
      endcase
      id_off = pos - cpd_pkg::PosIdStart;
      if (pos >= cpd_pkg::PosIdStart && id_off[1:0] == 2'b11) begin
        if (last_four <= prior_id) bad_packet = 1'b1;
        prior_id = last_four;
        item = '0;
        item.kind = cpd_pkg::KindId;
        item.unit_id = last_four;
        expected_items.insert(expected_items.size(), item);
      end
      rx_count = pos + 1'b1;
    end
    if (last) begin
      pkt_len  = {1'b0, pos} + 1'b1;
      want_len = 36'(cpd_pkg::HeaderBytes) + {2'b00, hdr_count, 2'b00};
      ok = !bad_packet;
      if (pkt_len < cpd_pkg::LenW'(cpd_pkg::HeaderBytes)) ok = 1'b0;
      if (hdr_count == '0 || hdr_count > cpd_pkg::MaxIds) ok = 1'b0;
      if (36'(pkt_len) != want_len) ok = 1'b0;
      if (hdr_player >= cpd_pkg::PlayerLimit) ok = 1'b0;
      if (hdr_seq == '0) ok = 1'b0;
      if (hdr_order > cpd_pkg::OrderMax) ok = 1'b0;
      if (hdr_x >= lim_x) ok = 1'b0;
      if (hdr_z >= lim_z) ok = 1'b0;
      item = '0;
      item.kind     = cpd_pkg::KindVerdict;
      item.accepted = ok;
      item.tick     = hdr_tick;
      item.seq      = hdr_seq;
      item.player   = hdr_player;
      item.order    = hdr_order;
      item.x        = hdr_x;
      item.z        = hdr_z;
      item.count    = hdr_count;
      expected_items.insert(expected_items.size(), item);
      restart_packet();
    end
  endtask

  task automatic field_check(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      mismatches_o++;
    end
  endtask

  task automatic check_item(input result_item_t want);
    field_check("item_kind", 32'(want.kind), 32'(result_i.item_kind));
    field_check("unit_id", want.unit_id, result_i.unit_id);
    field_check("accepted", 32'(want.accepted), 32'(result_i.accepted));
    field_check("tick_value", want.tick, result_i.tick_value);
    field_check("sequence_value", want.seq, result_i.sequence_value);
    field_check("player_value", 32'(want.player), 32'(result_i.player_value));
    field_check("order_value", 32'(want.order), 32'(result_i.order_value));
    field_check("x_value", want.x, result_i.x_value);
    field_check("z_value", want.z, result_i.z_value);
    field_check("id_count", want.count, result_i.id_count);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      restart_packet();
      lim_x = cpd_pkg::LimitReset;
      lim_z = cpd_pkg::LimitReset;
      expected_items.delete();
    end else begin
      if (cfg_i.valid === 1'b1 && cfg_i.ready === 1'b1) begin
        case (cfg_i.index)
          cpd_pkg::CfgXLimit: lim_x = cfg_i.data;
          cpd_pkg::CfgZLimit: lim_z = cfg_i.data;
          default: ;
        endcase
      end
      if (byte_i.valid === 1'b1 && byte_i.ready === 1'b1) begin
        decode_byte(byte_i.data_byte, byte_i.end_of_packet);
      end
      if (result_i.valid === 1'b1 && result_i.ready === 1'b1) begin
        if (expected_items.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, actual kind %0h id %0h",
                   $time, result_i.item_kind, result_i.unit_id);
          mismatches_o++;
        end else begin
          check_item(expected_items.pop_front());
        end
      end
    end
    pending_o = expected_items.size();
  end

endmodule

// ===== tb/tb_command_packet_deserializer_top.sv =====
`timescale 1ns / 100ps
// tb_command_packet_deserializer_top: stimulus and verdict for the command packet
// deserializer; builds packets byte by byte, writes the limit registers, stalls results
// depends on cpd_pkg, cpd_channels, cpd_packet_checker and the design
module tb_command_packet_deserializer_top;

  localparam int ClkHalf       = 4;
  localparam int ResetCycles   = 12;
  localparam int IdlePercent   = 13;
  localparam int HoldOffCycles = 300;
  localparam int SettleCycles  = 8;
  localparam int PhaseCount    = 7;
  localparam int PhaseBytes    = 60;
  localparam int unsigned CycleLimit = 500000;
  // an index that maps to no register, must be ignored
  localparam logic [cpd_pkg::CfgIdxW-1:0] CfgSpare = cpd_pkg::CfgIdxW'(2);

  // ways of spoiling a packet
  typedef enum int {
    FaultNone,
    FaultMagic,
    FaultShort,
    FaultLong,
    FaultCount,
    FaultIdOrder,
    FaultField,
    FaultCoord
  } fault_e;

  typedef struct packed {
    logic [31:0] tick;
    logic [31:0] seq;
    logic [7:0]  player;
    logic [7:0]  order;
    logic [31:0] x;
    logic [31:0] z;
    logic [31:0] count;
  } cmd_header_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cpd_byte_if   byte_bus ();
  cpd_cfg_if    cfg_bus ();
  cpd_result_if result_bus ();

  int          pending_count;
  int          mismatch_count;
  int unsigned cycle_count = 0;

  // shared between the byte sender and the result receiver
  bit no_idle     = 1'b0;
  bit holdoff_req = 1'b0;

  // limits currently programmed, used to aim coordinates near the edge
  logic [31:0] x_lim_now = cpd_pkg::LimitReset;
  logic [31:0] z_lim_now = cpd_pkg::LimitReset;

  // bytes of the packet being sent
  logic [7:0] pkt_q[$];

  always #ClkHalf clk_i = ~clk_i;

  command_packet_deserializer_top u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_bus),
    .cfg_i    (cfg_bus),
    .result_o (result_bus)
  );

  cpd_packet_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_bus),
    .cfg_i        (cfg_bus),
    .result_i     (result_bus),
    .pending_o    (pending_count),
    .mismatches_o (mismatch_count)
  );

  // hard stop if the design hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** command_packet_deserializer_top: FAILED **");
      $finish;
    end
  end

  // append one byte to the packet being built
  task automatic add_byte(input logic [7:0] b);
    pkt_q.insert(pkt_q.size(), b);
  endtask

  // little-endian word into the byte queue
  task automatic push_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) add_byte(w[8*k +: 8]);
  endtask

  task automatic serialise(input cmd_header_t h, input logic [31:0] ids[$]);
    pkt_q.delete();
    add_byte(cpd_pkg::MagicV);
    add_byte(cpd_pkg::MagicF);
    add_byte(cpd_pkg::MagicC);
    add_byte(cpd_pkg::Version);
    push_word(h.tick);
    push_word(h.seq);
    add_byte(h.player);
    add_byte(h.order);
    push_word(h.x);
    push_word(h.z);
    push_word(h.count);
    foreach (ids[k]) push_word(ids[k]);
  endtask

  // coordinate mostly inside the limit, often right on its last legal value
  function automatic logic [31:0] coord_pick(input logic [31:0] lim);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (lim == '0) return $urandom;
    if (roll < 2) return lim - 1'b1;
    if (roll < 3) return '0;
    return $urandom % lim;
  endfunction

  // well formed packet with random content, then the chosen fault on top;
  // surplus adds ids beyond the count field
  task automatic make_packet(input int id_num, input int surplus, input fault_e fault);
    cmd_header_t h;
    logic [31:0] ids[$];
    logic [31:0] prev;
    int          spread;
    int          k;
    int          n;
    h.tick = $urandom;
    h.seq  = $urandom;
    if (h.seq == '0) h.seq = 32'd1;
    h.player = 8'($urandom_range(0, cpd_pkg::PlayerLimit - 1));
    h.order  = 8'($urandom_range(0, cpd_pkg::OrderMax));
    h.x      = coord_pick(x_lim_now);
    h.z      = coord_pick(z_lim_now);
    h.count  = id_num;
    // tight or wide id spacing, always strictly rising from above zero
    spread = ($urandom_range(0, 1) == 0) ? 8 : (1 << 20);
    prev = '0;
    for (k = 0; k < id_num + surplus; k++) begin
      prev = prev + $urandom_range(1, spread);
      ids.insert(ids.size(), prev);
    end
    case (fault)
      FaultCount:
        case ($urandom_range(0, 3))
          0:       h.count = '0;
          1:       h.count = cpd_pkg::MaxIds + 1;
          2:       h.count = id_num + 1;
          default: h.count = $urandom;
        endcase
      FaultIdOrder: begin
        // first id of zero, or an id that does not rise
        k = $urandom_range(0, ids.size() - 1);
        if (k == 0) ids[0] = '0;
        else ids[k] = ids[k-1] - $urandom_range(0, 2);
      end
      FaultField:
        case ($urandom_range(0, 2))
          0:       h.seq = '0;
          1:       h.player = 8'($urandom_range(cpd_pkg::PlayerLimit, 255));
          default: h.order = 8'($urandom_range(cpd_pkg::OrderMax + 1, 255));
        endcase
      FaultCoord: begin
        if ($urandom_range(0, 1) == 0) h.x = x_lim_now + $urandom_range(0, 3);
        else h.z = z_lim_now + $urandom_range(0, 3);
      end
      default: ;
    endcase
    serialise(h, ids);
    case (fault)
      FaultMagic: begin
        k = $urandom_range(0, 3);
        pkt_q[k] = pkt_q[k] ^ 8'($urandom_range(1, 255));
      end
      FaultShort: begin
        // cut anywhere, down to a single byte
        n = $urandom_range(1, pkt_q.size() - 1);
        repeat (n) void'(pkt_q.pop_back());
      end
      FaultLong: repeat ($urandom_range(1, 9)) add_byte(8'($urandom));
      default: ;
    endcase
  endtask

  // one byte transaction, with random idle cycles in front of it
  task automatic offer_byte(input logic [7:0] b, input logic last);
    while (!no_idle && $urandom_range(0, 99) < IdlePercent) begin
      byte_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_bus.valid         <= 1'b1;
    byte_bus.data_byte     <= b;
    byte_bus.end_of_packet <= last;
    do @(posedge clk_i); while (byte_bus.ready !== 1'b1);
  endtask

  task automatic send_packet();
    foreach (pkt_q[k]) offer_byte(pkt_q[k], k == pkt_q.size() - 1);
  endtask

  // register write; keep_valid leaves valid up for a write that follows at once
  task automatic write_cfg(input logic [cpd_pkg::CfgIdxW-1:0] idx, input logic [31:0] value,
                           input logic keep_valid);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    if (!keep_valid) cfg_bus.valid <= 1'b0;
  endtask

  // stop sending until every predicted result has come back, then let the pipe settle
  task automatic drain();
    byte_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // result receiver: random back-pressure plus one long hold-off on request
  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        result_bus.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      result_bus.ready <= no_idle || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  initial begin
    cmd_header_t h;
    logic [31:0] ids[$];
    logic [31:0] new_x;
    logic [31:0] new_z;
    int          ph;
    int          sent;
    int          pkt_n;
    int          id_num;
    int          roll;
    fault_e      fault;

    byte_bus.valid         <= 1'b0;
    byte_bus.data_byte     <= '0;
    byte_bus.end_of_packet <= 1'b0;
    cfg_bus.valid          <= 1'b0;
    cfg_bus.index          <= '0;
    cfg_bus.data           <= '0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: lone final bytes at both byte extremes, far too short
    offer_byte(8'hFF, 1'b1);
    offer_byte(8'h00, 1'b1);
    // directed: minimal legal packet at reset limits, header words at their extremes,
    // last byte finishes the only id so the id item and the verdict come together
    h.tick   = '1;
    h.seq    = 32'd1;
    h.player = cpd_pkg::PlayerLimit - 8'd1;
    h.order  = cpd_pkg::OrderMax;
    h.x      = x_lim_now - 1'b1;
    h.z      = '0;
    h.count  = 32'd1;
    ids      = {32'hFFFF_FFFF};
    serialise(h, ids);
    send_packet();
    drain();

    // random phases, each under its own pair of limits
    for (ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: begin
          new_x = 32'd1;
          new_z = 32'h8000_0000;
        end
        1: begin
          new_x = 32'h8000_0000;
          new_z = 32'd1;
        end
        2: begin
          // zero limit, nothing can pass
          new_x = '0;
          new_z = cpd_pkg::LimitReset;
        end
        3: begin
          new_x = '1;
          new_z = '1;
        end
        4: begin
          new_x = $urandom_range(1, 1 << 16);
          new_z = $urandom_range(1, 1 << 16);
        end
        default: begin
          new_x = $urandom;
          new_z = $urandom;
        end
      endcase
      write_cfg(cpd_pkg::CfgXLimit, new_x, 1'b1);
      write_cfg(cpd_pkg::CfgZLimit, new_z, ph == 2);
      if (ph == 2) write_cfg(CfgSpare, $urandom, 1'b0);
      x_lim_now = new_x;
      z_lim_now = new_z;

      // one phase runs with neither side idling
      no_idle = (ph == 5);
      sent    = 0;
      pkt_n   = 0;
      while (sent < PhaseBytes) begin
        roll = $urandom_range(0, 19);
        if (roll < 14) id_num = $urandom_range(1, 6);
        else if (roll < 19) id_num = $urandom_range(7, 24);
        else id_num = $urandom_range(25, 64);
        if ($urandom_range(0, 9) < 7) fault = FaultNone;
        else fault = fault_e'($urandom_range(FaultMagic, FaultCoord));
        // long result stall while a big packet keeps coming, fills the queue
        if (ph == 4 && pkt_n == 0) begin
          holdoff_req = 1'b1;
          id_num      = 40;
          fault       = FaultNone;
        end
        make_packet(id_num, 0, fault);
        send_packet();
        sent += pkt_q.size();
        pkt_n++;
        // sender waits mid phase until all results are back
        if (ph == 5 && pkt_n == 3) drain();
      end
      // largest legal count
      if (ph == 3) begin
        make_packet(cpd_pkg::MaxIds, 0, FaultNone);
        send_packet();
      end
      drain();
    end
    no_idle = 1'b0;

    if (mismatch_count == 0) begin
      $display("** command_packet_deserializer_top: PASSED **");
    end else begin
      $display("** command_packet_deserializer_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/cpd_pkg.sv
design/cpd_channels.sv
design/cpd_front.sv
design/cpd_queue.sv
design/cpd_back.sv
design/command_packet_deserializer_top.sv
tb/cpd_packet_checker.sv
tb/tb_command_packet_deserializer_top.sv
